FILE: sv/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg
// shared sizes, transaction kind codes and interface structs for the
// descending end-time merge iterator
// ----------------------------------------------------------------------------
package dtm_pkg;

    localparam int NUM_LISTS   = 8;
    localparam int MAX_ENTRIES = 64;

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int POS_W  = $clog2(MAX_ENTRIES + 1);
    localparam int DEPTH  = NUM_LISTS * MAX_ENTRIES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int KIND_W  = 3;
    localparam int INDEX_W = 3;
    localparam int TIME_W  = 64;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEEK   = 3'd4;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] end_time;
        logic              at_present;
        logic              list_full;
    } result_t;

endpackage

FILE: sv/dtm_time_ram.sv
// ----------------------------------------------------------------------------
// dtm_time_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module dtm_time_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/dtm_ctrl.sv
// ----------------------------------------------------------------------------
// dtm_ctrl
// sequencer that owns list counts and cursors and walks the time ram for
// the maximum pass and the step-back pass
// ----------------------------------------------------------------------------
module dtm_ctrl
    import dtm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [KIND_W-1:0]  kind,
    input  logic [INDEX_W-1:0] list_index,
    input  logic [TIME_W-1:0]  time_value,
    output logic               idle,
    output logic               done,
    input  logic               done_ack,
    output result_t            result,
    output mem_req_t           mem_req,
    input  logic [TIME_W-1:0]  mem_rdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LAT_RD   = 3'd1;
    localparam logic [2:0] S_LAT_CHK  = 3'd2;
    localparam logic [2:0] S_BACK_RD  = 3'd3;
    localparam logic [2:0] S_BACK_CHK = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    localparam logic [LIST_W-1:0] LAST_LIST = LIST_W'(NUM_LISTS - 1);

    logic [2:0]        state_reg;
    logic [LIST_W-1:0] list_reg;
    logic [POS_W-1:0]  count_reg  [NUM_LISTS];
    logic [POS_W-1:0]  cursor_reg [NUM_LISTS];
    logic [TIME_W-1:0] best_reg;
    logic              none_reg;
    logic [TIME_W-1:0] limit_reg;
    result_t           result_reg;

    logic [LIST_W-1:0] app_list;
    logic              app_ok;
    logic [POS_W-1:0]  app_count;
    logic              app_full;
    logic [POS_W-1:0]  cur_pos;
    logic [TIME_W-1:0] best_new;

    function automatic logic [ADDR_W-1:0] entry_addr(logic [LIST_W-1:0] lst,
                                                     logic [IDX_W-1:0]  idx);
        entry_addr = ADDR_W'(ADDR_W'(lst) * ADDR_W'(MAX_ENTRIES) + ADDR_W'(idx));
    endfunction

    assign app_list  = LIST_W'(list_index);
    assign app_ok    = 32'(list_index) < NUM_LISTS;
    assign app_count = count_reg[app_list];
    assign app_full  = app_count == POS_W'(MAX_ENTRIES);
    assign cur_pos   = cursor_reg[list_reg];
    assign best_new  = (mem_rdata > best_reg) ? mem_rdata : best_reg;

    always_comb
    begin
        mem_req.wdata = time_value;
        mem_req.we    = start && (kind == KIND_APPEND) && app_ok && !app_full;
        if (state_reg == S_IDLE)
        begin
            mem_req.addr = entry_addr(app_list, IDX_W'(app_count));
        end
        else
        begin
            mem_req.addr = entry_addr(list_reg, IDX_W'(cur_pos - 1'b1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            list_reg   <= '0;
            result_reg <= '0;
            best_reg   <= '0;
            none_reg   <= 1'b1;
            limit_reg  <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                count_reg[i]  <= '0;
                cursor_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        result_reg.end_time   <= '0;
                        result_reg.at_present <= 1'b0;
                        result_reg.list_full  <= (kind == KIND_APPEND) && app_ok && app_full;
                        best_reg              <= '0;
                        none_reg              <= 1'b1;
                        list_reg              <= '0;
                        limit_reg             <= time_value - 1'b1;
                        unique case (kind)
                            KIND_CLEAR:
                            begin
                                for (int i = 0; i < NUM_LISTS; i++)
                                begin
                                    count_reg[i]  <= '0;
                                    cursor_reg[i] <= '0;
                                end
                                state_reg <= S_DONE;
                            end
                            KIND_APPEND:
                            begin
                                if (app_ok && !app_full)
                                begin
                                    count_reg[app_list] <= app_count + 1'b1;
                                end
                                state_reg <= S_DONE;
                            end
                            KIND_FIRST:
                            begin
                                for (int i = 0; i < NUM_LISTS; i++)
                                begin
                                    cursor_reg[i] <= count_reg[i];
                                end
                                state_reg <= S_LAT_RD;
                            end
                            KIND_NEXT:  state_reg <= S_LAT_RD;
                            KIND_SEEK:  state_reg <= S_BACK_RD;
                            default:    state_reg <= S_DONE;
                        endcase
                    end
                end
                S_LAT_RD:
                begin
                    if (cur_pos != '0)
                    begin
                        state_reg <= S_LAT_CHK;
                    end
                    else if (list_reg == LAST_LIST)
                    begin
                        // maximum is final, now walk cursors back below it
                        result_reg.end_time   <= best_reg;
                        result_reg.at_present <= none_reg;
                        limit_reg             <= best_reg - 1'b1;
                        list_reg              <= '0;
                        state_reg             <= S_BACK_RD;
                    end
                    else
                    begin
                        list_reg <= list_reg + 1'b1;
                    end
                end
                S_LAT_CHK:
                begin
                    best_reg <= best_new;
                    none_reg <= 1'b0;
                    if (list_reg == LAST_LIST)
                    begin
                        result_reg.end_time   <= best_new;
                        result_reg.at_present <= 1'b0;
                        limit_reg             <= best_new - 1'b1;
                        list_reg              <= '0;
                        state_reg             <= S_BACK_RD;
                    end
                    else
                    begin
                        list_reg  <= list_reg + 1'b1;
                        state_reg <= S_LAT_RD;
                    end
                end
                S_BACK_RD:
                begin
                    if (cur_pos != '0)
                    begin
                        state_reg <= S_BACK_CHK;
                    end
                    else if (list_reg == LAST_LIST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        list_reg <= list_reg + 1'b1;
                    end
                end
                S_BACK_CHK:
                begin
                    if (mem_rdata > limit_reg)
                    begin
                        // step this cursor back and look at the earlier entry
                        cursor_reg[list_reg] <= cur_pos - 1'b1;
                        state_reg            <= S_BACK_RD;
                    end
                    else if (list_reg == LAST_LIST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        list_reg  <= list_reg + 1'b1;
                        state_reg <= S_BACK_RD;
                    end
                end
                S_DONE:
                begin
                    if (done_ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign idle   = state_reg == S_IDLE;
    assign done   = state_reg == S_DONE;
    assign result = result_reg;

endmodule

FILE: sv/descending_end_time_merge_iterator_unit.sv
// ----------------------------------------------------------------------------
// descending_end_time_merge_iterator_unit
// k-way descending merge over lists of event times with per-list cursors
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Clear, append and unused kinds go
// straight to the done state for the hand-off. First and next make a maximum
// pass over all lists (a list with an exhausted cursor is skipped, a live
// cursor's top entry is read and then checked) and then a step-back pass
// (exhausted lists skipped, each entry examined read and then checked); seek
// does only the step-back pass. Every entry visit costs a read of the
// single-port time ram, which has registered read data. The result sits in
// an output register, so the next transaction may be taken while it waits.
module descending_end_time_merge_iterator_unit
    import dtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // list_index [2:0], time_value [66:3], zero [71:67]
    input  logic [2:0]  s_tuser,   // kind [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // end_time [63:0]
    output logic [1:0]  m_tuser    // at_present [0], list_full [1]
);

    logic        start;
    logic        ctrl_idle;
    logic        ctrl_done;
    logic        slot_free;
    result_t     ctrl_result;
    mem_req_t    mem_req;
    logic [63:0] mem_rdata;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [1:0]  out_user_reg;

    assign s_tready  = ctrl_idle;
    assign start     = s_tvalid && ctrl_idle;
    assign slot_free = !out_valid_reg || m_tready;

    dtm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (s_tuser),
        .list_index (s_tdata[2:0]),
        .time_value (s_tdata[66:3]),
        .idle       (ctrl_idle),
        .done       (ctrl_done),
        .done_ack   (slot_free),
        .result     (ctrl_result),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    dtm_time_ram #(
        .DEPTH (DEPTH),
        .WIDTH (TIME_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= ctrl_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && ctrl_done)
        begin
            out_data_reg <= ctrl_result.end_time;
            out_user_reg <= {ctrl_result.list_full, ctrl_result.at_present};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: sv/dtm_checker.sv
// ----------------------------------------------------------------------------
// dtm_checker
// port-level checks for the merge iterator, bound to the top level
// ----------------------------------------------------------------------------
module dtm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // output stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a taken transaction leaves the sequencer busy, so no second one is taken back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken back to back");

    // a dropped append carries no time and no present flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata == 64'd0) && !m_tuser[0])
        else $error("list_full result with other fields set");

    // all cursors exhausted means the reported time is the present
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
        else $error("at_present result with nonzero end_time");

endmodule

bind descending_end_time_merge_iterator_unit dtm_checker u_dtm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
